[rtl/h264sft_pkg.sv]
package h264sft_pkg;

    // Longest Exp-Golomb prefix honored before the prefix is forced to end
    localparam int MaxPrefixZeros = 32;
    // Width of the running I-slice counter
    localparam int CountWidth = 32;
    // Width of zero run and suffix counters
    localparam int RunWidth = $clog2(MaxPrefixZeros + 1);

    // NAL unit types of interest
    localparam logic [4:0] NAL_SLICE_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR      = 5'd5;
    localparam logic [4:0] NAL_SEI           = 5'd6;
    localparam logic [4:0] NAL_SPS           = 5'd7;
    localparam logic [4:0] NAL_PPS           = 5'd8;

    // Frame class codes
    localparam logic [2:0] CLS_UNKNOWN = 3'd0;
    localparam logic [2:0] CLS_I       = 3'd1;
    localparam logic [2:0] CLS_P       = 3'd2;
    localparam logic [2:0] CLS_B       = 3'd3;
    localparam logic [2:0] CLS_SEI     = 3'd4;
    localparam logic [2:0] CLS_SPS     = 3'd5;
    localparam logic [2:0] CLS_PPS     = 3'd6;

    // Slice type values of true I slices (SI slices are not counted)
    localparam logic [3:0] SLICE_TYPE_I     = 4'd2;
    localparam logic [3:0] SLICE_TYPE_I_ALL = 4'd7;

    // Slice accumulator saturation point (leading one plus suffix)
    localparam logic [4:0] ACCUM_SAT = 5'd16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP_PREFIX,
        PH_SKIP_SUFFIX,
        PH_TYPE_PREFIX,
        PH_TYPE_SUFFIX
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [RunWidth-1:0] zero_run;
        logic [RunWidth-1:0] suffix_left;
        logic [4:0]          accum;
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [3:0]  slice_type_value;
        logic [31:0] intra_count;
    } t_out_item;

    // Map slice_type 0..9 to a frame class; above nine is unknown
    function automatic logic [2:0] class_of_type(input logic [3:0] val);
        logic [2:0] cls;
        case (val)
            4'd0, 4'd3, 4'd5, 4'd8: cls = CLS_P;
            4'd1, 4'd6:             cls = CLS_B;
            4'd2, 4'd4, 4'd7, 4'd9: cls = CLS_I;
            default:                cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

[rtl/h264_slice_frame_type_parser_core.sv]
// H.264 slice frame type parser.
//
// Input channel (i_valid / o_stall, payload i_data): one byte of a NAL unit
// per transaction, start code removed, first_byte set on the header byte and
// last_byte set on the final byte. Output channel (o_valid / i_stall, payload
// o_data): at most one result per unit, carrying the frame class, the decoded
// slice_type (saturated at 15) and the running I-slice count.
//
// Throughput: one byte per cycle while o_stall is low. The eight bit steps of the
// Exp-Golomb walker are evaluated between the parser state register and the
// result register, so each accepted byte updates the state register directly.
// A completing byte (header byte, slice type end or truncating last byte)
// registers its result into the output register, or into the skid register on a stall.
//
// When the receiver stalls, the result register holds and one more result
// may land in a skid register; o_stall is that skid register's full flag, so
// no result is lost and the input side never waits on i_stall directly.
//
// Reset (i_rst_n low, synchronous) returns the parser to idle, clears the
// I-slice counter and empties both output registers.
module h264_slice_frame_type_parser_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  h264sft_pkg::t_in_item  i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output h264sft_pkg::t_out_item o_data
);

    localparam int RW = h264sft_pkg::RunWidth;

    // Advance the parser by one payload bit; set done when slice_type ends
    function automatic h264sft_pkg::t_parse_state step_bit(
        input  h264sft_pkg::t_parse_state st,
        input  logic                      b,
        output logic                      done
    );
        h264sft_pkg::t_parse_state ns;
        logic                      prefix_end;
        logic [5:0]                acc_wide;
        ns         = st;
        done       = 1'b0;
        prefix_end = b || (st.zero_run >= RW'(h264sft_pkg::MaxPrefixZeros));
        acc_wide   = {st.accum, b};
        case (st.phase)
            h264sft_pkg::PH_SKIP_PREFIX: begin
                if (prefix_end) begin
                    ns.suffix_left = st.zero_run;
                    ns.zero_run    = '0;
                    ns.phase       = (st.zero_run != '0) ? h264sft_pkg::PH_SKIP_SUFFIX
                                                         : h264sft_pkg::PH_TYPE_PREFIX;
                end else begin
                    ns.zero_run = st.zero_run + RW'(1);
                end
            end
            h264sft_pkg::PH_SKIP_SUFFIX: begin
                ns.suffix_left = st.suffix_left - RW'(1);
                if (ns.suffix_left == '0) begin
                    ns.phase = h264sft_pkg::PH_TYPE_PREFIX;
                end
            end
            h264sft_pkg::PH_TYPE_PREFIX: begin
                if (prefix_end) begin
                    ns.suffix_left = st.zero_run;
                    ns.zero_run    = '0;
                    ns.accum       = 5'd1;
                    if (st.zero_run == '0) begin
                        done     = 1'b1;
                        ns.phase = h264sft_pkg::PH_IDLE;
                    end else begin
                        ns.phase = h264sft_pkg::PH_TYPE_SUFFIX;
                    end
                end else begin
                    ns.zero_run = st.zero_run + RW'(1);
                end
            end
            h264sft_pkg::PH_TYPE_SUFFIX: begin
                ns.accum = (acc_wide > {1'b0, h264sft_pkg::ACCUM_SAT})
                         ? h264sft_pkg::ACCUM_SAT : acc_wide[4:0];
                ns.suffix_left = st.suffix_left - RW'(1);
                if (ns.suffix_left == '0) begin
                    done     = 1'b1;
                    ns.phase = h264sft_pkg::PH_IDLE;
                end
            end
            default: begin
                ns = st;
            end
        endcase
        return ns;
    endfunction

    h264sft_pkg::t_parse_state           r_st, n_st;
    logic [h264sft_pkg::CountWidth-1:0]  r_count, n_count;
    h264sft_pkg::t_out_item              r_out, r_skid, n_res;
    logic                                r_out_valid, r_skid_valid;
    logic                                n_emit;

    h264sft_pkg::t_parse_state           bit_st [0:8];
    logic [7:0]                          bit_done;
    logic                                accept;
    logic                                out_ready;
    logic                                any_done;
    logic [3:0]                          type_val;
    logic [2:0]                          type_cls;
    logic [4:0]                          unit_type;

    assign accept    = i_valid && !r_skid_valid;
    assign out_ready = !r_out_valid || !i_stall;
    assign o_stall   = r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign unit_type = i_data.data_byte[4:0];

    // Walk the payload byte MSB first; bits after completion fall through idle
    always_comb begin
        bit_st[0] = r_st;
        for (int k = 0; k < 8; k++) begin
            bit_st[k+1] = step_bit(bit_st[k], i_data.data_byte[7-k], bit_done[k]);
        end
    end

    assign any_done = |bit_done;
    assign type_val = 4'(bit_st[8].accum - 5'd1);
    assign type_cls = h264sft_pkg::class_of_type(type_val);

    always_comb begin
        n_st    = r_st;
        n_count = r_count;
        n_emit  = 1'b0;
        n_res.frame_class      = h264sft_pkg::CLS_UNKNOWN;
        n_res.slice_type_value = 4'd0;
        if (i_data.first_byte) begin
            // Header byte: restart the unit, classify non-slices and header-only slices at once
            n_st.phase       = h264sft_pkg::PH_IDLE;
            n_st.zero_run    = '0;
            n_st.suffix_left = '0;
            n_st.accum       = '0;
            case (unit_type)
                h264sft_pkg::NAL_SLICE_NON_IDR, h264sft_pkg::NAL_TYPE_IDR: begin
                    if (i_data.last_byte) begin
                        n_emit = 1'b1;
                    end else begin
                        n_st.phase = h264sft_pkg::PH_SKIP_PREFIX;
                    end
                end
                h264sft_pkg::NAL_SEI: begin
                    n_emit = 1'b1;
                    n_res.frame_class = h264sft_pkg::CLS_SEI;
                end
                h264sft_pkg::NAL_SPS: begin
                    n_emit = 1'b1;
                    n_res.frame_class = h264sft_pkg::CLS_SPS;
                end
                h264sft_pkg::NAL_PPS: begin
                    n_emit = 1'b1;
                    n_res.frame_class = h264sft_pkg::CLS_PPS;
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end else if (r_st.phase != h264sft_pkg::PH_IDLE) begin
            n_st = bit_st[8];
            if (any_done) begin
                n_emit = 1'b1;
                n_res.frame_class      = type_cls;
                n_res.slice_type_value = type_val;
                // Count true I slices only; SI slices class as I but do not count
                if (type_val == h264sft_pkg::SLICE_TYPE_I ||
                    type_val == h264sft_pkg::SLICE_TYPE_I_ALL) begin
                    n_count = r_count + h264sft_pkg::CountWidth'(1);
                end
            end else if (i_data.last_byte) begin
                // Truncated slice: end the unit with an unknown result
                n_emit     = 1'b1;
                n_st.phase = h264sft_pkg::PH_IDLE;
            end
        end
        n_res.intra_count = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase       <= h264sft_pkg::PH_IDLE;
            r_st.zero_run    <= '0;
            r_st.suffix_left <= '0;
            r_st.accum       <= '0;
            r_count          <= '0;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_st    <= n_st;
                r_count <= n_count;
            end
            if (out_ready) begin
                // Drain the skid first; it always holds the older result
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (accept && n_emit) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept && n_emit) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // The skid register only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // The I-slice counter moves only on an accepted I-slice result
    a_count_only_on_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && n_emit && n_res.frame_class == h264sft_pkg::CLS_I) |=> $stable(r_count))
        else $error("I-slice counter changed without an I slice");

    // An I class result carries slice type 2, 4, 7 or 9
    a_i_class_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_class == h264sft_pkg::CLS_I) |->
        (o_data.slice_type_value == 4'd2 || o_data.slice_type_value == 4'd4 ||
         o_data.slice_type_value == 4'd7 || o_data.slice_type_value == 4'd9))
        else $error("I class with a non-intra slice type");

    // Parameter-set and SEI results carry no slice type
    a_non_slice_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.frame_class == h264sft_pkg::CLS_SEI ||
                     o_data.frame_class == h264sft_pkg::CLS_SPS ||
                     o_data.frame_class == h264sft_pkg::CLS_PPS)) |->
        (o_data.slice_type_value == 4'd0))
        else $error("non-slice result with nonzero slice type");

endmodule

[tb/h264_slice_frame_type_parser_core_tb.sv]
`timescale 1ns / 100ps

class nal_class_predictor;
    // Parser state, tracked byte by byte as transactions are accepted
    h264sft_pkg::t_phase phase;
    logic [4:0]  unit_type;
    int unsigned zero_run;
    int unsigned suffix_left;
    int unsigned accum;
    logic [31:0] intra_total;
    logic [2:0]  class_of_value [0:9];

    h264sft_pkg::t_out_item pending_classes[$];
    int unsigned bytes_parsed;
    int unsigned mismatches;

    function new();
        phase = h264sft_pkg::PH_IDLE;
        unit_type = '0;
        zero_run = 0;
        suffix_left = 0;
        accum = 0;
        intra_total = '0;
        bytes_parsed = 0;
        mismatches = 0;
        class_of_value = '{h264sft_pkg::CLS_P, h264sft_pkg::CLS_B, h264sft_pkg::CLS_I,
                           h264sft_pkg::CLS_P, h264sft_pkg::CLS_I, h264sft_pkg::CLS_P,
                           h264sft_pkg::CLS_B, h264sft_pkg::CLS_I, h264sft_pkg::CLS_P,
                           h264sft_pkg::CLS_I};
    endfunction

    function void push_class(logic [2:0] cls, logic [3:0] val);
        h264sft_pkg::t_out_item r;
        r.frame_class = cls;
        r.slice_type_value = val;
        r.intra_count = intra_total;
        pending_classes.push_back(r);
    endfunction

    // Walk one payload bit; return 1 when the slice type field completes
    function bit take_bit(bit b);
        case (phase)
            h264sft_pkg::PH_SKIP_PREFIX: begin
                if (b || zero_run >= h264sft_pkg::MaxPrefixZeros) begin
                    suffix_left = zero_run;
                    zero_run = 0;
                    if (suffix_left != 0) phase = h264sft_pkg::PH_SKIP_SUFFIX;
                    else phase = h264sft_pkg::PH_TYPE_PREFIX;
                end else begin
                    zero_run++;
                end
            end
            h264sft_pkg::PH_SKIP_SUFFIX: begin
                suffix_left--;
                if (suffix_left == 0) phase = h264sft_pkg::PH_TYPE_PREFIX;
            end
            h264sft_pkg::PH_TYPE_PREFIX: begin
                if (b || zero_run >= h264sft_pkg::MaxPrefixZeros) begin
                    suffix_left = zero_run;
                    zero_run = 0;
                    accum = 1;
                    if (suffix_left == 0) return 1'b1;
                    phase = h264sft_pkg::PH_TYPE_SUFFIX;
                end else begin
                    zero_run++;
                end
            end
            h264sft_pkg::PH_TYPE_SUFFIX: begin
                accum = accum * 2 + b;
                if (accum > 16) accum = 16;
                suffix_left--;
                return suffix_left == 0;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function void note_byte(h264sft_pkg::t_in_item it);
        int unsigned val;
        if (it.first_byte) begin
            bytes_parsed++;
            unit_type = it.data_byte[4:0];
            zero_run = 0;
            suffix_left = 0;
            accum = 0;
            phase = h264sft_pkg::PH_IDLE;
            if (unit_type == h264sft_pkg::NAL_SLICE_NON_IDR ||
                unit_type == h264sft_pkg::NAL_TYPE_IDR) begin
                if (it.last_byte) push_class(h264sft_pkg::CLS_UNKNOWN, 4'd0);
                else phase = h264sft_pkg::PH_SKIP_PREFIX;
            end else if (unit_type == h264sft_pkg::NAL_SEI) begin
                push_class(h264sft_pkg::CLS_SEI, 4'd0);
            end else if (unit_type == h264sft_pkg::NAL_SPS) begin
                push_class(h264sft_pkg::CLS_SPS, 4'd0);
            end else if (unit_type == h264sft_pkg::NAL_PPS) begin
                push_class(h264sft_pkg::CLS_PPS, 4'd0);
            end else begin
                push_class(h264sft_pkg::CLS_UNKNOWN, 4'd0);
            end
            return;
        end
        if (phase == h264sft_pkg::PH_IDLE) return;
        bytes_parsed++;
        for (int k = 7; k >= 0; k--) begin
            if (take_bit(it.data_byte[k])) begin
                val = accum - 1;
                phase = h264sft_pkg::PH_IDLE;
                if (val < 10) begin
                    if (val == 2 || val == 7) intra_total++;
                    push_class(class_of_value[val], 4'(val));
                end else begin
                    push_class(h264sft_pkg::CLS_UNKNOWN, 4'(val));
                end
                return;
            end
        end
        if (it.last_byte) begin
            phase = h264sft_pkg::PH_IDLE;
            push_class(h264sft_pkg::CLS_UNKNOWN, 4'd0);
        end
    endfunction

    task flag_mismatch(string msg);
        if (mismatches < 50) $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_result(h264sft_pkg::t_out_item got);
        h264sft_pkg::t_out_item want;
        if (pending_classes.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        want = pending_classes.pop_front();
        if (got.frame_class !== want.frame_class)
            flag_mismatch($sformatf("frame_class %0d, wanted %0d",
                                    got.frame_class, want.frame_class));
        if (got.slice_type_value !== want.slice_type_value)
            flag_mismatch($sformatf("slice_type_value %0d, wanted %0d",
                                    got.slice_type_value, want.slice_type_value));
        if (got.intra_count !== want.intra_count)
            flag_mismatch($sformatf("intra_count %0d, wanted %0d",
                                    got.intra_count, want.intra_count));
    endtask
endclass

module h264_slice_frame_type_parser_core_tb;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    h264sft_pkg::t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    h264sft_pkg::t_out_item o_data;

    // Idle and stall odds, in percent, set per phase by the stimulus process
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    // Length of a one-shot receiver hold-off; the receiver process consumes it
    int unsigned hold_request = 0;

    nal_class_predictor tracker;

    // Bitstream under construction and the bytes of the unit about to go out
    bit         code_bits[$];
    logic [7:0] unit_bytes[$];

    h264_slice_frame_type_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offer one byte, idling at random first; return once the transaction is taken
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
        h264sft_pkg::t_in_item item;
        item.data_byte = data;
        item.first_byte = first;
        item.last_byte = last;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_byte(item);
    endtask

    // Send unit_bytes as one unit; leave last_byte clear to abandon it midway
    task automatic send_unit(input bit mark_last);
        for (int i = 0; i < unit_bytes.size(); i++)
            send_byte(unit_bytes[i], i == 0, mark_last && i == unit_bytes.size() - 1);
    endtask

    // Append the Exp-Golomb code of v: n zeros, then v+1 in n+1 bits
    function automatic void push_ue(longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        repeat (n) code_bits.push_back(1'b0);
        for (int k = n; k >= 0; k--) code_bits.push_back(x[k]);
    endfunction

    // Append a maximal prefix whose terminating bit is random, then 32 suffix bits
    function automatic void push_long_prefix();
        repeat (h264sft_pkg::MaxPrefixZeros) code_bits.push_back(1'b0);
        repeat (h264sft_pkg::MaxPrefixZeros + 1) code_bits.push_back(1'($urandom));
    endfunction

    task automatic send_slice_unit();
        int unsigned pick;
        logic [7:0] b;
        bit mark_last;
        code_bits.delete();
        unit_bytes.delete();
        unit_bytes.push_back({3'($urandom),
                              ($urandom_range(1) == 1) ? h264sft_pkg::NAL_TYPE_IDR
                                                       : h264sft_pkg::NAL_SLICE_NON_IDR});
        // First macroblock field: mostly short codes
        pick = $urandom_range(99);
        if (pick < 80) push_ue($urandom_range(300));
        else if (pick < 90) push_ue($urandom_range(1 << 20));
        else push_long_prefix();
        // Slice type field: mostly legal, some above nine, some saturating
        pick = $urandom_range(99);
        if (pick < 70) push_ue($urandom_range(9));
        else if (pick < 85) push_ue($urandom_range(40, 10));
        else if (pick < 93) push_ue($urandom);
        else push_long_prefix();
        // Pad out with random trailing slice header bits
        repeat ($urandom_range(20)) code_bits.push_back(1'($urandom));
        while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom));
        for (int i = 0; i < code_bits.size(); i += 8) begin
            b = '0;
            for (int j = 0; j < 8; j++) b = {b[6:0], code_bits[i + j]};
            unit_bytes.push_back(b);
        end
        repeat ($urandom_range(2)) unit_bytes.push_back(8'($urandom));
        // Damage a minority: cut the unit short, or drop its last_byte
        pick = $urandom_range(99);
        mark_last = 1'b1;
        if (pick < 10) begin
            pick = $urandom_range(unit_bytes.size() - 1);
            while (unit_bytes.size() > pick + 1) void'(unit_bytes.pop_back());
        end else if (pick < 15) begin
            mark_last = 1'b0;
        end
        send_unit(mark_last);
    endtask

    task automatic send_other_unit();
        logic [4:0] kind;
        unit_bytes.delete();
        if ($urandom_range(1) == 1) kind = 5'(h264sft_pkg::NAL_SEI + $urandom_range(2));
        else kind = 5'($urandom);
        unit_bytes.push_back({3'($urandom), kind});
        repeat ($urandom_range(4)) unit_bytes.push_back(8'($urandom));
        send_unit($urandom_range(9) != 0);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned hold_cycles);
        int unsigned target;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        hold_request = hold_cycles;
        target = tracker.bytes_parsed + 460;
        while (tracker.bytes_parsed < target) begin
            pick = $urandom_range(99);
            if (pick < 70) send_slice_unit();
            else if (pick < 90) send_other_unit();
            else if (pick < 95) send_byte(8'($urandom), 1'b0, 1'($urandom));
            else send_byte(8'($urandom), $urandom_range(3) == 0, 1'($urandom));
        end
    endtask

    // Receiver: stall at random, or hold off for a whole requested stretch
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Check every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_result(o_data);
    end

    initial begin : stimulus
        int unsigned drain_cycles;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a stray byte while idle is dropped without a result
        send_byte(8'hA5, 1'b0, 1'b0);
        // Header-only units: SEI, SPS, PPS, other types, and a slice cut at its header
        unit_bytes = '{8'h06};
        send_unit(1'b1);
        unit_bytes = '{8'h67};
        send_unit(1'b1);
        unit_bytes = '{8'h68};
        send_unit(1'b1);
        unit_bytes = '{8'hFF};
        send_unit(1'b1);
        unit_bytes = '{8'h00};
        send_unit(1'b1);
        unit_bytes = '{8'h65};
        send_unit(1'b1);
        // I slice (type 7) with bytes after completion, then I slice (type 2)
        unit_bytes = '{8'h41, 8'h88, 8'h12};
        send_unit(1'b1);
        unit_bytes = '{8'h25, 8'hB8};
        send_unit(1'b1);
        // Slice type above nine, at the saturation point of fifteen
        unit_bytes = '{8'h01, 8'h84, 8'h00};
        send_unit(1'b1);
        // Abandon a slice with a new header, whose macroblock field has a
        // maximal prefix ended by a zero bit
        send_byte(8'h41, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        unit_bytes = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h40};
        send_unit(1'b1);

        // Random phases; the first one holds the receiver off long enough
        // to fill the output registers and push back on the input
        run_phase(0, 0, 400);
        run_phase(71, 0, 0);
        run_phase(0, 71, 0);
        run_phase(11, 11, 0);

        // Drain: stop offering, let the outstanding results come out
        i_valid <= 1'b0;
        receiver_stall_pct = 0;
        drain_cycles = 0;
        while (tracker.pending_classes.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (tracker.pending_classes.size() != 0)
            tracker.flag_mismatch($sformatf("%0d results never arrived",
                                            tracker.pending_classes.size()));
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/h264sft_pkg.sv
rtl/h264_slice_frame_type_parser_core.sv
tb/h264_slice_frame_type_parser_core_tb.sv
